>>> sv/crrhs_pkg.sv
// ----------------------------------------------------------------------------
// crrhs_pkg
// Shared types and constants of the round-robin host selector.
// ----------------------------------------------------------------------------
package crrhs_pkg;

	localparam int HOST_W     = 3;
	localparam int CNT_W      = 8;
	localparam int TYPE_W     = 4;
	localparam int HCNT_W     = 4;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int IN_W       = 24;
	localparam int OUT_W      = 16;

	typedef enum logic [1:0] {
		OP_REQUEST = 2'd0,
		OP_INC     = 2'd1,
		OP_DEC     = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_HOST_COUNT = 3'd0,
		CFG_HOST_LIMITS = 3'd1,
		CFG_CAPS_LOW   = 3'd2,
		CFG_CAPS_HIGH  = 3'd3,
		CFG_ACCEPT_ALL = 3'd4
	} cfg_idx_t;

	// one input item
	typedef struct packed {
		logic [HOST_W-1:0] target_host;
		logic              any_agent;
		logic [TYPE_W-1:0] agent_type;
		logic [CNT_W-1:0]  slots_needed;
		op_t               opcode;
	} item_t;

	// one result item
	typedef struct packed {
		logic              load_clamped;
		logic [CNT_W-1:0]  load_now;
		logic [HOST_W-1:0] chosen_host;
		logic              found;
	} result_t;

	// what the staging register takes this cycle
	typedef enum logic [1:0] {
		STG_HOLD,
		STG_FOUND,
		STG_ZERO,
		STG_LOAD
	} stage_t;

	typedef struct packed {
		logic   capture;
		logic   scan_next;
		logic   rotate;
		logic   load_upd;
		stage_t stage;
		logic   publish;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic fit;
		logic last_pos;
	} stat_t;

endpackage

>>> sv/capacity_round_robin_host_select.sv
// ----------------------------------------------------------------------------
// capacity_round_robin_host_select
// Round-robin first-fit host selection with per-host load counts.
// ----------------------------------------------------------------------------
// Input stream s_*: one item per transfer (request, increase or decrease load).
// Output stream m_*: exactly one result per input item, in order.
// Configuration: write cfg_wdata to register cfg_addr while cfg_we is high,
// only while the block is idle.
// An accepted item is captured, then decoded: load items apply their saturating
// change and stage their result, while a request scans the service order one
// position per cycle until a host fits or the last position has been tried.
// The unused opcode stages an empty result. The next item is accepted once
// the result has moved to the output register, even if the receiver has not
// taken it yet.
// When m_tready is low the result holds in the output register and the
// block stalls after staging the following result.
// Reset restores the identity service order, clears all running counts,
// clears the configuration and sets every host to accept all agent types.
// ----------------------------------------------------------------------------
module capacity_round_robin_host_select import crrhs_pkg::*; #(
	parameter int MAX_HOSTS   = 8,
	parameter int AGENT_TYPES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// opcode[1:0], slots_needed[9:2], agent_type[13:10], any_agent[14],
	// target_host[17:15], zero fill above
	input  logic [IN_W-1:0]       s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// found[0], chosen_host[3:1], load_now[11:4], load_clamped[12], zero fill above
	output logic [OUT_W-1:0]      m_tdata
);

	item_t   item;
	result_t result;
	cmd_t    cmd;
	stat_t   stat;

	assign item.opcode       = op_t'(s_tdata[1:0]);
	assign item.slots_needed = s_tdata[9:2];
	assign item.agent_type   = s_tdata[13:10];
	assign item.any_agent    = s_tdata[14];
	assign item.target_host  = s_tdata[17:15];

	assign m_tdata = {{(OUT_W - $bits(result_t)){1'b0}}, result};

	crrhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	crrhs_dp #(
		.MAX_HOSTS   (MAX_HOSTS),
		.AGENT_TYPES (AGENT_TYPES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule

>>> sv/crrhs_ctrl.sv
// ----------------------------------------------------------------------------
// crrhs_ctrl
// Controller: sequences capture, scan, load update and result hand-off.
// ----------------------------------------------------------------------------
module crrhs_ctrl import crrhs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	output logic  m_tvalid,
	input  logic  m_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LOAD,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		cmd = '0;
		cmd.stage = STG_HOLD;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = s_tvalid;
			end
			ST_SCAN: begin
				if (stat.fit) begin
					cmd.rotate = 1'b1;
					cmd.stage  = STG_FOUND;
				end else if (stat.last_pos) begin
					cmd.stage = STG_ZERO;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			ST_LOAD: begin
				// requests only pass through on their way to the scan
				if (stat.op == OP_NOP) begin
					cmd.stage = STG_ZERO;
				end else if (stat.op != OP_REQUEST) begin
					cmd.load_upd = 1'b1;
					cmd.stage    = STG_LOAD;
				end
			end
			ST_RESULT: begin
				cmd.publish = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						// opcode is read after capture, so branch in the next state
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					// requests leave the load state at once for the scan
					if (stat.op == OP_REQUEST) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_RESULT;
					end
				end
				ST_SCAN: begin
					if (stat.fit || stat.last_pos) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/crrhs_dp.sv
// ----------------------------------------------------------------------------
// crrhs_dp
// Datapath: configuration, service order, running counts, scan and results.
// ----------------------------------------------------------------------------
module crrhs_dp import crrhs_pkg::*; #(
	parameter int MAX_HOSTS   = 8,
	parameter int AGENT_TYPES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  item_t                 item,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	output result_t               result
);

	localparam int PW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;

	logic [HCNT_W-1:0]     host_count_q;
	logic [63:0]           host_limits_q;
	logic [63:0]           caps_low_q;
	logic [63:0]           caps_high_q;
	logic [7:0]            accept_all_q;

	item_t                 item_q;
	logic [PW-1:0]         pos_q;
	logic [HOST_W-1:0]     order_q [MAX_HOSTS];
	logic [CNT_W-1:0]      running_q [MAX_HOSTS];
	result_t               stage_q;
	result_t               out_q;

	logic [HCNT_W-1:0]     n_hosts;
	logic [HOST_W-1:0]     scan_host;
	logic [HOST_W-1:0]     rd_host;
	logic [CNT_W-1:0]      cur_cnt;
	logic [CNT_W-1:0]      limit;
	logic [15:0]           type_mask;
	logic [63:0]           caps_word;
	logic                  host_used;
	logic                  room_ok;
	logic                  type_ok;
	logic                  tgt_ok;
	logic                  sat;
	logic [CNT_W-1:0]      nxt_cnt;

	assign n_hosts = (host_count_q > HCNT_W'(MAX_HOSTS)) ? HCNT_W'(MAX_HOSTS) : host_count_q;

	assign scan_host = order_q[pos_q];
	assign rd_host   = (item_q.opcode == OP_REQUEST) ? scan_host : item_q.target_host;
	assign cur_cnt   = running_q[rd_host[PW-1:0]];

	// fit test of the host at the current scan position
	assign host_used = ({1'b0, scan_host} < n_hosts);
	assign limit     = host_limits_q[scan_host*CNT_W +: CNT_W];
	assign room_ok   = ({1'b0, limit} >= ({1'b0, cur_cnt} + {1'b0, item_q.slots_needed}));
	assign caps_word = scan_host[2] ? caps_high_q : caps_low_q;
	assign type_mask = caps_word[scan_host[1:0]*16 +: 16];
	assign type_ok   = item_q.any_agent || accept_all_q[scan_host] ||
		(({1'b0, item_q.agent_type} < 5'(AGENT_TYPES)) && type_mask[item_q.agent_type]);

	assign stat.op       = item_q.opcode;
	assign stat.fit      = host_used && room_ok && type_ok;
	assign stat.last_pos = (pos_q == PW'(MAX_HOSTS - 1));

	// saturating load change on the target host
	assign tgt_ok = ({1'b0, item_q.target_host} < n_hosts);
	always_comb begin
		if (item_q.opcode == OP_INC) begin
			sat     = (cur_cnt == {CNT_W{1'b1}});
			nxt_cnt = sat ? cur_cnt : cur_cnt + CNT_W'(1);
		end else begin
			sat     = (cur_cnt == '0);
			nxt_cnt = sat ? cur_cnt : cur_cnt - CNT_W'(1);
		end
	end

	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_count_q  <= '0;
			host_limits_q <= '0;
			caps_low_q    <= '0;
			caps_high_q   <= '0;
			accept_all_q  <= 8'hFF;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_HOST_COUNT:  host_count_q  <= cfg_wdata[HCNT_W-1:0];
				CFG_HOST_LIMITS: host_limits_q <= cfg_wdata;
				CFG_CAPS_LOW:    caps_low_q    <= cfg_wdata;
				CFG_CAPS_HIGH:   caps_high_q   <= cfg_wdata;
				CFG_ACCEPT_ALL:  accept_all_q  <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int i = 0; i < MAX_HOSTS; i++) begin
				order_q[i]   <= HOST_W'(i);
				running_q[i] <= '0;
			end
		end else begin
			if (cmd.capture) begin
				pos_q <= '0;
			end else if (cmd.scan_next) begin
				pos_q <= pos_q + PW'(1);
			end
			// drop the chosen host out of its place and append it at the back
			if (cmd.rotate) begin
				for (int i = 0; i < MAX_HOSTS - 1; i++) begin
					if (PW'(i) >= pos_q) begin
						order_q[i] <= order_q[i + 1];
					end
				end
				order_q[MAX_HOSTS - 1] <= scan_host;
			end
			if (cmd.load_upd && tgt_ok && !sat) begin
				running_q[item_q.target_host[PW-1:0]] <= nxt_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		unique case (cmd.stage)
			STG_HOLD: begin
			end
			STG_FOUND: begin
				stage_q.found        <= 1'b1;
				stage_q.chosen_host  <= scan_host;
				stage_q.load_now     <= cur_cnt;
				stage_q.load_clamped <= 1'b0;
			end
			STG_ZERO: begin
				stage_q <= '0;
			end
			STG_LOAD: begin
				stage_q.found        <= tgt_ok;
				stage_q.chosen_host  <= item_q.target_host;
				stage_q.load_now     <= tgt_ok ? nxt_cnt : '0;
				stage_q.load_clamped <= tgt_ok && sat;
			end
			default: begin
			end
		endcase
		if (cmd.publish) begin
			out_q <= stage_q;
		end
	end

endmodule

>>> verif/capacity_round_robin_host_select_test.sv
// ----------------------------------------------------------------------------
// capacity_round_robin_host_select_test
// Self-checking stream testbench for the round-robin host selector.
// ----------------------------------------------------------------------------
// A short directed table comes first. It covers the reset state, the unused
// opcode, saturation at the bottom, capability masks, an oversized host count
// and hosts whose count is above their limit. Random phases follow under
// several register settings, the extremes among them. A model of the service
// order and of the per-host counts predicts every result that the table does
// not give. The monitor checks each output transfer field by field, in order.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module capacity_round_robin_host_select_test;
	timeunit 1ns;
	timeprecision 1ps;
	import crrhs_pkg::*;

	localparam int HOSTS       = 8;
	localparam int SETTLE      = 12;
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef enum logic {MIX_BALANCED, MIX_FILL} mix_t;

	typedef struct packed {
		logic     is_cfg;
		cfg_idx_t idx;
		logic [CFG_DATA_W-1:0] val;
		item_t    it;
		logic     typed;
		result_t  want;
	} plan_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_W-1:0]      m_tdata;

	// shadow of the block's registers and state
	logic [3:0]            cfg_hosts      = '0;
	logic [63:0]           cfg_limits     = '0;
	logic [63:0]           cfg_caps_lo    = '0;
	logic [63:0]           cfg_caps_hi    = '0;
	logic [7:0]            cfg_accept_all = 8'hFF;
	logic [HOST_W-1:0]     svc_order [HOSTS];
	logic [CNT_W-1:0]      host_load [HOSTS];

	result_t pending_results [$];
	bit      calm = 1'b0;
	int      rx_left = 0;
	int      n_err = 0, n_items = 0, n_writes = 0, n_cycles = 0;
	int      n_grants = 0, n_misses = 0, n_clamps = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	capacity_round_robin_host_select dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	function automatic int idle_gap();
		int k;
		k = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (k < 45)
			return 0;
		if (k < 85)
			return $urandom_range(1, 3);
		if (k < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// first fit in service order; the winner moves to the back
	function automatic result_t predict_selection(item_t it);
		result_t           r;
		int                n, pick;
		logic [HOST_W-1:0] h;
		logic [15:0]       mask;
		bit                fits;
		r = '0;
		n = (cfg_hosts > HOSTS) ? HOSTS : int'(cfg_hosts);
		case (it.opcode)
		OP_REQUEST: begin
			pick = -1;
			for (int p = 0; p < HOSTS; p++) begin
				h = svc_order[p];
				mask = h[2] ? cfg_caps_hi[int'(h[1:0]) * 16 +: 16]
				            : cfg_caps_lo[int'(h[1:0]) * 16 +: 16];
				fits = (int'(h) < n)
				    && (int'(cfg_limits[int'(h) * 8 +: 8])
				        >= int'(host_load[h]) + int'(it.slots_needed))
				    && (it.any_agent || cfg_accept_all[h] || mask[it.agent_type]);
				if (fits && pick < 0)
					pick = p;
			end
			if (pick >= 0) begin
				h = svc_order[pick];
				for (int p = pick; p < HOSTS - 1; p++)
					svc_order[p] = svc_order[p + 1];
				svc_order[HOSTS - 1] = h;
				r.found       = 1'b1;
				r.chosen_host = h;
				r.load_now    = host_load[h];
			end
		end
		OP_INC, OP_DEC: begin
			h = it.target_host;
			r.chosen_host = h;
			if (int'(h) < n) begin
				if (it.opcode == OP_INC) begin
					if (host_load[h] == 8'hFF)
						r.load_clamped = 1'b1;
					else
						host_load[h] = host_load[h] + 8'd1;
				end else begin
					if (host_load[h] == 8'h00)
						r.load_clamped = 1'b1;
					else
						host_load[h] = host_load[h] - 8'd1;
				end
				r.found    = 1'b1;
				r.load_now = host_load[h];
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic plan_row_t row_cfg(cfg_idx_t idx, logic [63:0] val);
		plan_row_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.idx    = idx;
		s.val    = val;
		return s;
	endfunction

	function automatic plan_row_t row_item(op_t op, int slots, int agent, bit any, int tgt,
			bit typed = 1'b0, bit found = 1'b0, int host = 0, int load = 0,
			bit clamp = 1'b0);
		plan_row_t s;
		s = '0;
		s.it.opcode            = op;
		s.it.slots_needed      = 8'(slots);
		s.it.agent_type        = 4'(agent);
		s.it.any_agent         = any;
		s.it.target_host       = 3'(tgt);
		s.typed                = typed;
		s.want.found           = found;
		s.want.chosen_host     = 3'(host);
		s.want.load_now        = 8'(load);
		s.want.load_clamped    = clamp;
		return s;
	endfunction

	function automatic item_t random_item(mix_t mix, logic [HOST_W-1:0] hot);
		item_t it;
		int    k;
		k = $urandom_range(0, 9);
		it.slots_needed = (k < 7) ? 8'($urandom_range(0, 3))
		                : (k < 9) ? 8'($urandom_range(0, 20)) : 8'($urandom_range(0, 255));
		it.agent_type  = 4'($urandom_range(0, 15));
		it.any_agent   = ($urandom_range(0, 3) == 0);
		it.target_host = 3'($urandom_range(0, 7));
		k = $urandom_range(0, 99);
		if (mix == MIX_FILL) begin
			if (k < 85) begin
				it.opcode      = OP_INC;
				it.target_host = hot;
			end else if (k < 95) begin
				it.opcode = OP_REQUEST;
			end else begin
				it.opcode = OP_DEC;
			end
		end else begin
			if (k < 55)
				it.opcode = OP_REQUEST;
			else if (k < 78)
				it.opcode = OP_INC;
			else if (k < 97)
				it.opcode = OP_DEC;
			else
				it.opcode = OP_NOP;
		end
		return it;
	endfunction

	function automatic logic [63:0] small_limits(int top);
		logic [63:0] v;
		for (int i = 0; i < HOSTS; i++)
			v[i * 8 +: 8] = 8'($urandom_range(0, top));
		return v;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_err++;
		end
	endfunction

	// keep tvalid high across back-to-back transfers; lower it only for a gap
	task automatic send_item(item_t it, bit typed, result_t want);
		int      gap;
		result_t model;
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'(it);
		do @(posedge clk); while (!s_tready);
		model = predict_selection(it);
		pending_results.push_back(typed ? want : model);
		n_items++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_idx_t idx, logic [63:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		CFG_HOST_COUNT:  cfg_hosts      = val[3:0];
		CFG_HOST_LIMITS: cfg_limits     = val;
		CFG_CAPS_LOW:    cfg_caps_lo    = val;
		CFG_CAPS_HIGH:   cfg_caps_hi    = val;
		CFG_ACCEPT_ALL:  cfg_accept_all = val[7:0];
		default: ;
		endcase
		n_writes++;
	endtask

	task automatic configure(logic [63:0] hosts, logic [63:0] limits, logic [63:0] caps_lo,
			logic [63:0] caps_hi, logic [63:0] accept_all);
		wait_idle();
		cfg_write(CFG_HOST_COUNT, hosts);
		cfg_write(CFG_HOST_LIMITS, limits);
		cfg_write(CFG_CAPS_LOW, caps_lo);
		cfg_write(CFG_CAPS_HIGH, caps_hi);
		cfg_write(CFG_ACCEPT_ALL, accept_all);
	endtask

	task automatic random_phase(int count, mix_t mix);
		logic [HOST_W-1:0] hot;
		hot = 3'($urandom_range(0, 7));
		for (int i = 0; i < count; i++) begin
			// now and then hold the sender until the block has drained
			if ($urandom_range(0, 99) == 0)
				wait_idle();
			send_item(random_item(mix, hot), 1'b0, '0);
		end
	endtask

	// receiver: ready stretches alternate with stalls of random length
	always @(posedge clk) begin
		if (rx_left > 0) begin
			rx_left <= rx_left - 1;
		end else if (calm || !m_tready) begin
			m_tready <= 1'b1;
			rx_left  <= $urandom_range(0, 15);
		end else begin
			m_tready <= 1'b0;
			rx_left  <= idle_gap();
		end
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[$bits(result_t)-1:0]);
			if (pending_results.size() == 0) begin
				$error("unexpected output transfer: m_tdata=%h", m_tdata);
				n_err++;
			end else begin
				want = pending_results.pop_front();
				check_field("found", 8'(want.found), 8'(got.found));
				check_field("chosen_host", 8'(want.chosen_host), 8'(got.chosen_host));
				check_field("load_now", want.load_now, got.load_now);
				check_field("load_clamped", 8'(want.load_clamped), 8'(got.load_clamped));
				if (want.found && !want.load_clamped)
					n_grants++;
				if (!want.found)
					n_misses++;
				if (want.load_clamped)
					n_clamps++;
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("[capacity_round_robin_host_select] ERROR");
			$finish;
		end
	end

	initial begin
		plan_row_t plan [$];
		for (int i = 0; i < HOSTS; i++) begin
			svc_order[i] = 3'(i);
			host_load[i] = '0;
		end
		plan = '{
			// no hosts in use after reset
			row_item(OP_REQUEST, 0, 0, 1, 0, 1, 0, 0, 0, 0),
			row_item(OP_REQUEST, 255, 15, 0, 0, 1, 0, 0, 0, 0),
			row_item(OP_INC, 0, 0, 0, 3, 1, 0, 3, 0, 0),
			row_item(OP_DEC, 0, 0, 0, 7, 1, 0, 7, 0, 0),
			row_item(OP_NOP, 255, 15, 1, 7, 1, 0, 0, 0, 0),
			row_cfg(CFG_HOST_COUNT, 64'd8),
			row_cfg(CFG_HOST_LIMITS, '1),
			row_item(OP_REQUEST, 0, 0, 0, 0, 1, 1, 0, 0, 0),
			row_item(OP_REQUEST, 255, 15, 0, 0, 1, 1, 1, 0, 0),
			row_item(OP_DEC, 0, 0, 0, 5, 1, 1, 5, 0, 1),
			row_item(OP_INC, 0, 0, 0, 7, 1, 1, 7, 1, 0),
			row_item(OP_INC, 0, 0, 0, 7),
			row_item(OP_REQUEST, 254, 3, 1, 0),
			// capability masks only
			row_cfg(CFG_ACCEPT_ALL, 64'd0),
			row_cfg(CFG_CAPS_LOW, 64'd0),
			row_cfg(CFG_CAPS_HIGH, 64'd0),
			row_item(OP_REQUEST, 0, 5, 0, 0, 1, 0, 0, 0, 0),
			row_item(OP_REQUEST, 0, 5, 1, 0),
			row_cfg(CFG_CAPS_HIGH, 64'h0000_0200_0000_0000),
			row_item(OP_REQUEST, 0, 9, 0, 0, 1, 1, 6, 0, 0),
			row_item(OP_REQUEST, 0, 8, 0, 0, 1, 0, 0, 0, 0),
			row_cfg(CFG_CAPS_LOW, '1),
			row_item(OP_REQUEST, 3, 15, 0, 0),
			// oversized host count acts as all eight
			row_cfg(CFG_HOST_COUNT, 64'd15),
			row_item(OP_INC, 0, 0, 0, 7),
			row_cfg(CFG_HOST_COUNT, 64'd2),
			row_item(OP_INC, 0, 0, 0, 5, 1, 0, 5, 0, 0),
			row_item(OP_INC, 0, 0, 0, 1),
			// host 1 now runs above a zero limit
			row_cfg(CFG_HOST_LIMITS, 64'd0),
			row_item(OP_REQUEST, 0, 0, 1, 0),
			row_item(OP_REQUEST, 1, 0, 1, 0, 1, 0, 0, 0, 0),
			row_cfg(CFG_CAPS_LOW, 64'h0000_0000_FFFF_0000),
			row_item(OP_REQUEST, 0, 2, 0, 0, 1, 0, 0, 0, 0)
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				wait_idle();
				cfg_write(plan[i].idx, plan[i].val);
			end else begin
				send_item(plan[i].it, plan[i].typed, plan[i].want);
			end
		end

		configure(64'd8, small_limits(6), {$urandom, $urandom}, {$urandom, $urandom},
			64'($urandom_range(0, 255)));
		random_phase(200, MIX_BALANCED);
		// drive one host into saturation at the top
		configure(64'd8, '1, 64'd0, 64'd0, 64'hFF);
		random_phase(360, MIX_FILL);
		configure(64'd3, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			64'd0);
		random_phase(150, MIX_BALANCED);
		calm = 1'b1;
		configure(64'd15, small_limits(8), '1, '1, 64'd0);
		random_phase(150, MIX_BALANCED);
		calm = 1'b0;
		configure(64'd0, '1, '1, '1, 64'hFF);
		random_phase(40, MIX_BALANCED);
		configure(64'd1, 64'd0, {$urandom, $urandom}, {$urandom, $urandom}, 64'd0);
		random_phase(50, MIX_BALANCED);
		configure(64'd9, small_limits(10), {$urandom, $urandom}, {$urandom, $urandom},
			64'($urandom_range(0, 255)));
		random_phase(200, MIX_BALANCED);
		wait_idle();

		$display("Checked %0d transfers: %0d grants or load changes, %0d misses, %0d clamps",
			n_items, n_grants, n_misses, n_clamps);
		$display("Register writes: %0d over the directed table and seven random settings, %s",
			n_writes, "stalls on both stream sides");
		if (n_err == 0)
			$display("[capacity_round_robin_host_select] OK");
		else
			$display("[capacity_round_robin_host_select] ERROR");
		$finish;
	end

endmodule
